FILE: design/assert_macros.svh
// assertion macros shared by the rtl, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: design/svpwm_pkg.sv
// types, constants and sector codes of the svpwm duty calculator
package svpwm_pkg;

    localparam int DUTY_WIDTH      = 16;
    localparam int FRAC_BITS       = 15;
    localparam int VOLT_W          = 16;
    localparam int PERIOD_W        = 16;
    localparam int OUT_W           = 16;
    localparam int UNIT_LOG        = FRAC_BITS + 16;
    localparam int U_W             = 34;
    localparam int TIME_W          = 32;
    localparam int SUM_W           = TIME_W + 1;
    localparam int QUO_W           = UNIT_LOG + 1;
    localparam int TWICE_W         = UNIT_LOG + 2;
    localparam int JOB_QUEUE_DEPTH = 4;

    // half a period in internal time units
    localparam logic [UNIT_LOG:0] UNIT = {1'b1, {UNIT_LOG{1'b0}}};

    // sqrt(3)/2 in q0.16
    localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    typedef logic [2:0] sector_t;

    // sign codes u1 + 2*u2 + 4*u3
    localparam sector_t SEC_ZERO = 3'd0;
    localparam sector_t SEC_1    = 3'd1;
    localparam sector_t SEC_2    = 3'd2;
    localparam sector_t SEC_3    = 3'd3;
    localparam sector_t SEC_4    = 3'd4;
    localparam sector_t SEC_5    = 3'd5;
    localparam sector_t SEC_6    = 3'd6;
    localparam sector_t SEC_ALL  = 3'd7;

    typedef struct packed {
        logic signed [VOLT_W-1:0] alpha_volt;
        logic signed [VOLT_W-1:0] beta_volt;
    } svpwm_vec_t;

    typedef struct packed {
        logic [OUT_W-1:0] duty_a;
        logic [OUT_W-1:0] duty_b;
        logic [OUT_W-1:0] duty_c;
        logic [2:0]       sector_code;
        logic             overmodulated;
    } svpwm_duty_t;

    // classified item handed from front to back
    typedef struct packed {
        sector_t           code;
        logic              over;
        logic [TIME_W-1:0] tx;
        logic [TIME_W-1:0] ty;
        logic [SUM_W-1:0]  sum;
    } svpwm_job_t;

endpackage

FILE: design/svpwm_fifo.sv
// short job queue between the front and the back
module svpwm_fifo
    import svpwm_pkg::*;
#(
    parameter int DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  svpwm_job_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output svpwm_job_t rd_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    svpwm_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/svpwm_front.sv
// front: takes vectors, forms u1 u2 u3, finds the sector and active times
module svpwm_front
    import svpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  svpwm_vec_t vec,
    input  logic       q_full,
    output logic       q_push,
    output svpwm_job_t job
);

    svpwm_vec_t               vec_reg;
    logic                     s1_valid_reg;
    logic signed [U_W-1:0]    u1_reg;
    logic signed [U_W-1:0]    u2_reg;
    logic signed [U_W-1:0]    u3_reg;
    logic                     s2_valid_reg;

    logic                     adv1;
    logic                     adv2;
    logic signed [32:0]       prod;
    logic signed [U_W-1:0]    b_ext;
    logic signed [U_W-1:0]    u1_next;
    logic signed [U_W-1:0]    u2_next;
    logic signed [U_W-1:0]    u3_next;
    logic signed [U_W-1:0]    tx_s;
    logic signed [U_W-1:0]    ty_s;
    sector_t                  code;
    logic [SUM_W-1:0]         sum;

    // stall control
    assign adv2   = !s2_valid_reg || !q_full;
    assign adv1   = !s1_valid_reg || adv2;
    assign full   = !adv1;
    assign q_push = s2_valid_reg && !q_full;

    // projections onto the three phase axes
    always_comb
    begin
        prod    = vec_reg.alpha_volt * SQRT3_HALF_Q16;
        b_ext   = U_W'(vec_reg.beta_volt);
        u1_next = b_ext <<< 16;
        u2_next = -U_W'(prod) - (b_ext <<< 15);
        u3_next = U_W'(prod) - (b_ext <<< 15);
    end

    // sector code and the two active times
    always_comb
    begin
        code[0] = !u1_reg[U_W-1] && (u1_reg != '0);
        code[1] = !u2_reg[U_W-1] && (u2_reg != '0);
        code[2] = !u3_reg[U_W-1] && (u3_reg != '0);
        unique case (code)
            SEC_5:
            begin
                tx_s = u3_reg;
                ty_s = u1_reg;
            end
            SEC_1:
            begin
                tx_s = -u3_reg;
                ty_s = -u2_reg;
            end
            SEC_3:
            begin
                tx_s = u1_reg;
                ty_s = u2_reg;
            end
            SEC_2:
            begin
                tx_s = -u1_reg;
                ty_s = -u3_reg;
            end
            SEC_6:
            begin
                tx_s = u2_reg;
                ty_s = u3_reg;
            end
            SEC_4:
            begin
                tx_s = -u2_reg;
                ty_s = -u1_reg;
            end
            default:
            begin
                tx_s = '0;
                ty_s = '0;
            end
        endcase
        job.code = code;
        job.tx   = tx_s[TIME_W-1:0];
        job.ty   = ty_s[TIME_W-1:0];
        sum      = SUM_W'(tx_s[TIME_W-1:0]) + SUM_W'(ty_s[TIME_W-1:0]);
        job.sum  = sum;
        job.over = (sum > SUM_W'(UNIT));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= push;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv1 && push)
        begin
            vec_reg <= vec;
        end
        if (adv2)
        begin
            u1_reg <= u1_next;
            u2_reg <= u2_next;
            u3_reg <= u3_next;
        end
    end

endmodule

FILE: design/svpwm_back.sv
// back: overmodulation divide, phase times, duty scaling, result register
module svpwm_back
    import svpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PERIOD_W-1:0] period,
    input  svpwm_job_t          job,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output svpwm_duty_t         duty
);

    localparam int NUM_W  = TIME_W + UNIT_LOG;
    localparam int PROD_W = TWICE_W + PERIOD_W;
    localparam int D_W    = PROD_W - UNIT_LOG;

    typedef struct packed {
        sector_t           code;
        logic              over;
        logic [TIME_W-1:0] tx;
        logic [TIME_W-1:0] ty;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  rx;
        logic [SUM_W-1:0]  ry;
        logic [QUO_W-1:0]  lx;
        logic [QUO_W-1:0]  ly;
        logic [QUO_W-1:0]  qx;
        logic [QUO_W-1:0]  qy;
    } div_st_t;

    typedef struct packed {
        sector_t            code;
        logic               over;
        logic [TWICE_W-1:0] pa;
        logic [TWICE_W-1:0] pb;
        logic [TWICE_W-1:0] pc;
    } cmb_st_t;

    typedef struct packed {
        sector_t           code;
        logic              over;
        logic [PROD_W-1:0] ma;
        logic [PROD_W-1:0] mb;
        logic [PROD_W-1:0] mc;
    } mul_st_t;

    div_st_t            st_reg [QUO_W];
    logic [QUO_W-1:0]   st_valid_reg;
    cmb_st_t            cmb_reg;
    logic               cmb_valid_reg;
    mul_st_t            mul_reg;
    logic               mul_valid_reg;
    svpwm_duty_t        duty_reg;
    logic               out_valid_reg;

    logic               adv;
    div_st_t            last;
    cmb_st_t            cmb_next;
    logic [TWICE_W-1:0] tx_w;
    logic [TWICE_W-1:0] ty_w;
    logic [TWICE_W-1:0] t_full;
    logic [TWICE_W-1:0] t_one;
    logic [TWICE_W-1:0] t_zero;

    // load the remainder with the upper dividend bits, tx and ty shifted up by unit
    function automatic div_st_t div_init(svpwm_job_t j);
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        div_st_t          s;
        nx     = {j.tx, {UNIT_LOG{1'b0}}};
        ny     = {j.ty, {UNIT_LOG{1'b0}}};
        s.code = j.code;
        s.over = j.over;
        s.tx   = j.tx;
        s.ty   = j.ty;
        s.sum  = j.sum;
        s.rx   = SUM_W'(nx[NUM_W-1:QUO_W]);
        s.ry   = SUM_W'(ny[NUM_W-1:QUO_W]);
        s.lx   = nx[QUO_W-1:0];
        s.ly   = ny[QUO_W-1:0];
        s.qx   = '0;
        s.qy   = '0;
        return s;
    endfunction

    // one restoring step for both quotients
    function automatic div_st_t div_step(div_st_t s);
        logic [SUM_W:0] tx_r;
        logic [SUM_W:0] ty_r;
        logic [SUM_W:0] d;
        div_st_t        o;
        o    = s;
        d    = {1'b0, s.sum};
        tx_r = {s.rx, s.lx[QUO_W-1]};
        ty_r = {s.ry, s.ly[QUO_W-1]};
        if (tx_r >= d)
        begin
            o.rx = SUM_W'(tx_r - d);
            o.qx = {s.qx[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rx = tx_r[SUM_W-1:0];
            o.qx = {s.qx[QUO_W-2:0], 1'b0};
        end
        if (ty_r >= d)
        begin
            o.ry = SUM_W'(ty_r - d);
            o.qy = {s.qy[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.ry = ty_r[SUM_W-1:0];
            o.qy = {s.qy[QUO_W-2:0], 1'b0};
        end
        o.lx = s.lx << 1;
        o.ly = s.ly << 1;
        return o;
    endfunction

    // round half up, saturate to the duty range
    function automatic logic [OUT_W-1:0] to_duty(logic [PROD_W-1:0] p);
        logic [PROD_W:0] r;
        logic [D_W-1:0]  d;
        r = {1'b0, p} + (PROD_W + 1)'(UNIT);
        d = r[PROD_W:UNIT_LOG+1];
        if ((d >> DUTY_WIDTH) != '0)
        begin
            d = D_W'({DUTY_WIDTH{1'b1}});
        end
        return d[OUT_W-1:0];
    endfunction

    // whole pipeline moves unless the result register is held
    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !out_valid_reg;
    assign duty  = duty_reg;
    assign last  = st_reg[QUO_W-1];

    // phase times from the (possibly scaled) active times
    always_comb
    begin
        tx_w   = last.over ? TWICE_W'(last.qx) : TWICE_W'(last.tx);
        ty_w   = last.over ? TWICE_W'(last.qy) : TWICE_W'(last.ty);
        t_full = TWICE_W'(UNIT) + tx_w + ty_w;
        t_one  = TWICE_W'(UNIT) - tx_w + ty_w;
        t_zero = TWICE_W'(UNIT) - tx_w - ty_w;
        cmb_next.code = last.code;
        cmb_next.over = last.over;
        unique case (last.code)
            SEC_5:
            begin
                cmb_next.pa = t_full;
                cmb_next.pb = t_one;
                cmb_next.pc = t_zero;
            end
            SEC_1:
            begin
                cmb_next.pa = t_one;
                cmb_next.pb = t_full;
                cmb_next.pc = t_zero;
            end
            SEC_3:
            begin
                cmb_next.pa = t_zero;
                cmb_next.pb = t_full;
                cmb_next.pc = t_one;
            end
            SEC_2:
            begin
                cmb_next.pa = t_zero;
                cmb_next.pb = t_one;
                cmb_next.pc = t_full;
            end
            SEC_6:
            begin
                cmb_next.pa = t_one;
                cmb_next.pb = t_zero;
                cmb_next.pc = t_full;
            end
            SEC_4:
            begin
                cmb_next.pa = t_full;
                cmb_next.pb = t_zero;
                cmb_next.pc = t_one;
            end
            default:
            begin
                // zero vector or code 7: every phase at half period
                cmb_next.pa   = TWICE_W'(UNIT);
                cmb_next.pb   = TWICE_W'(UNIT);
                cmb_next.pc   = TWICE_W'(UNIT);
                cmb_next.over = 1'b0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            cmb_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg  <= {st_valid_reg[QUO_W-2:0], !q_empty};
            cmb_valid_reg <= st_valid_reg[QUO_W-1];
            mul_valid_reg <= cmb_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    // divider stages, phase times, products, result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= div_step(div_init(job));
            for (int k = 1; k < QUO_W; k++)
            begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
            cmb_reg              <= cmb_next;
            mul_reg.code         <= cmb_reg.code;
            mul_reg.over         <= cmb_reg.over;
            mul_reg.ma           <= PROD_W'(cmb_reg.pa) * PROD_W'(period);
            mul_reg.mb           <= PROD_W'(cmb_reg.pb) * PROD_W'(period);
            mul_reg.mc           <= PROD_W'(cmb_reg.pc) * PROD_W'(period);
            duty_reg.duty_a        <= to_duty(mul_reg.ma);
            duty_reg.duty_b        <= to_duty(mul_reg.mb);
            duty_reg.duty_c        <= to_duty(mul_reg.mc);
            duty_reg.sector_code   <= mul_reg.code;
            duty_reg.overmodulated <= mul_reg.over;
        end
    end

endmodule

FILE: design/svpwm_duty_calculator.sv
// top level: svpwm duty calculator with period register and job queue
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  vector   | push / full      | vec.alpha_volt, vec.beta_volt (q1.15)
//  duties   | pop / empty      | duty.duty_a/b/c, sector_code, overmodulated
//  config   | cfg_we           | cfg_data -> pwm period
//
//  one item per cycle sustained while results are popped; the back pipeline
//  divides with one quotient bit per stage.
//  reset clears all valid bits and loads the period with 1000.
//  a held result stalls the back; the queue then fills and full rises
//  only once the front's two stages are also occupied.
`include "assert_macros.svh"

module svpwm_duty_calculator
    import svpwm_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  svpwm_vec_t          vec,
    output logic                empty,
    input  logic                pop,
    output svpwm_duty_t         duty,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_data
);

    logic [PERIOD_W-1:0] pwm_period_reg;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    svpwm_job_t          job_in;
    svpwm_job_t          job_out;

    // period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            pwm_period_reg <= cfg_data;
        end
    end

    // classify
    svpwm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vec    (vec),
        .q_full (q_full),
        .q_push (q_push),
        .job    (job_in)
    );

    // decoupling queue
    svpwm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    // compute duties
    svpwm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .period  (pwm_period_reg),
        .job     (job_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .duty    (duty)
    );

    // checks
    `ASSERT_IMPLIES(a_zero_half, !empty && duty.sector_code == SEC_ZERO, duty.duty_a == duty.duty_b && duty.duty_b == duty.duty_c && !duty.overmodulated, "zero vector duties differ")
    `ASSERT_IMPLIES(a_over_sector, !empty && duty.overmodulated, duty.sector_code != SEC_ZERO && duty.sector_code != SEC_ALL, "overmodulation flagged without sector")
    `ASSERT_NEVER(a_duty_range, !empty && (duty.duty_a > pwm_period_reg || duty.duty_b > pwm_period_reg || duty.duty_c > pwm_period_reg), "duty above period")
    `ASSERT_IMPLIES(a_full_queue, full, q_full, "front stalled with room in queue")

endmodule
